// File: hw/rtl/gmpc_pkg.sv
// shared types and constants for the grid max path count block
`default_nettype none

package gmpc_pkg;

   localparam int COUNT_WIDTH = 5;
   localparam int SIZE_WIDTH  = 5;

   typedef logic [COUNT_WIDTH-1:0] count_type;
   typedef logic [SIZE_WIDTH-1:0]  size_type;

   localparam count_type COUNT_MAX  = 5'd31;
   localparam size_type  SIZE_RESET = 5'd16;

   // finished count handed from the path core to the result register
   typedef struct packed {
      logic      push;
      count_type count;
   } result_type;

endpackage

`default_nettype wire

// File: hw/rtl/gmpc_channels.sv
// valid/ready channel interfaces for grid cells and path counts
`default_nettype none

interface gmpc_req_if;
   logic valid;
   logic ready;
   logic cell_occupied;

   modport source (output valid, output cell_occupied, input ready);
   modport sink (input valid, input cell_occupied, output ready);
endinterface

interface gmpc_rsp_if;
   logic               valid;
   logic               ready;
   gmpc_pkg::count_type max_minerals;

   modport source (output valid, output max_minerals, input ready);
   modport sink (input valid, input max_minerals, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/gmpc_path_core.sv
// row-buffer DP over one grid, one cell per cycle unless the output stalls
`default_nettype none

module gmpc_path_core #(
   parameter int MAX_SIDE = 16
) (
   input  wire                   clock,
   input  wire                   reset,
   gmpc_req_if.sink              req_chan,
   input  wire                   csr_write_enable,
   input  gmpc_pkg::size_type    csr_write_data,
   input  wire                   slot_free,
   output gmpc_pkg::result_type  result
);

   localparam int IDX_W  = $clog2(MAX_SIDE);
   localparam int SIDE_W = $clog2(MAX_SIDE + 1);
   localparam int CMP_W  = (gmpc_pkg::SIZE_WIDTH > SIDE_W) ? gmpc_pkg::SIZE_WIDTH : SIDE_W;
   localparam int RESET_SIDE =
      (int'(gmpc_pkg::SIZE_RESET) > MAX_SIDE) ? MAX_SIDE :
      (int'(gmpc_pkg::SIZE_RESET) < 1) ? 1 : int'(gmpc_pkg::SIZE_RESET);

   logic [IDX_W-1:0]    row_ff, row_in;
   logic [IDX_W-1:0]    col_ff, col_in;
   logic [IDX_W-1:0]    last_idx_ff, last_idx_in;
   gmpc_pkg::count_type left_ff, left_in;
   gmpc_pkg::count_type up_ff;
   gmpc_pkg::count_type row_best [MAX_SIDE];

   logic [CMP_W-1:0]    size_ext;
   logic                is_last;
   logic                accept;
   gmpc_pkg::count_type prior;
   gmpc_pkg::count_type best;

   assign size_ext = CMP_W'(csr_write_data);

   // side length clamped to 1..MAX_SIDE, kept as the last index
   always_comb begin
      if (size_ext == '0) begin
         last_idx_in = '0;
      end else if (size_ext > CMP_W'(MAX_SIDE)) begin
         last_idx_in = IDX_W'(MAX_SIDE - 1);
      end else begin
         last_idx_in = IDX_W'(size_ext - CMP_W'(1));
      end
   end

   assign is_last = (row_ff == last_idx_ff) && (col_ff == last_idx_ff);
   // only the bottom-right cell needs room in the result register
   assign req_chan.ready = !is_last || slot_free;
   assign accept = req_chan.valid && req_chan.ready;

   always_comb begin
      if (row_ff != '0 && col_ff != '0) begin
         prior = (up_ff > left_ff) ? up_ff : left_ff;
      end else if (row_ff != '0) begin
         prior = up_ff;
      end else if (col_ff != '0) begin
         prior = left_ff;
      end else begin
         prior = '0;
      end
   end

   assign best = (prior == gmpc_pkg::COUNT_MAX) ? gmpc_pkg::COUNT_MAX
                                                : prior + gmpc_pkg::count_type'(req_chan.cell_occupied);

   always_comb begin
      row_in  = row_ff;
      col_in  = col_ff;
      left_in = left_ff;
      if (csr_write_enable) begin
         row_in  = '0;
         col_in  = '0;
         left_in = '0;
      end else if (accept) begin
         if (is_last) begin
            row_in  = '0;
            col_in  = '0;
            left_in = '0;
         end else if (col_ff == last_idx_ff) begin
            row_in  = row_ff + IDX_W'(1);
            col_in  = '0;
            left_in = best;
         end else begin
            col_in  = col_ff + IDX_W'(1);
            left_in = best;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff      <= '0;
         col_ff      <= '0;
         left_ff     <= '0;
         last_idx_ff <= IDX_W'(RESET_SIDE - 1);
      end else begin
         row_ff  <= row_in;
         col_ff  <= col_in;
         left_ff <= left_in;
         if (csr_write_enable) begin
            last_idx_ff <= last_idx_in;
         end
      end
   end

   // row buffer: write the current column, prefetch the next cell's column
   always_ff @(posedge clock) begin
      if (accept) begin
         row_best[col_ff] <= best;
      end
      up_ff <= row_best[col_in];
   end

   assign result.push  = accept && is_last;
   assign result.count = best;

`ifndef SYNTH
   a_col_in_grid: assert property (@(posedge clock) disable iff (reset)
      col_ff <= last_idx_ff)
      else $error("column index outside grid");

   a_row_in_grid: assert property (@(posedge clock) disable iff (reset)
      row_ff <= last_idx_ff)
      else $error("row index outside grid");

   a_col_advance: assert property (@(posedge clock) disable iff (reset)
      (accept && !csr_write_enable && col_ff != last_idx_ff)
      |=> (col_ff == IDX_W'($past(col_ff) + IDX_W'(1))) && (row_ff == $past(row_ff)))
      else $error("column did not advance after a cell");

   a_csr_restart: assert property (@(posedge clock) disable iff (reset)
      csr_write_enable |=> (row_ff == '0) && (col_ff == '0))
      else $error("size write did not restart the grid");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/gmpc_result_reg.sv
// output register that holds one finished count until it is taken
`default_nettype none

module gmpc_result_reg (
   input  wire                  clock,
   input  wire                  reset,
   input  gmpc_pkg::result_type result,
   output logic                 slot_free,
   gmpc_rsp_if.source           rsp_chan
);

   logic                valid_ff, valid_in;
   gmpc_pkg::count_type count_ff;

   assign slot_free = !valid_ff || rsp_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      if (result.push) begin
         valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (result.push) begin
         count_ff <= result.count;
      end
   end

   assign rsp_chan.valid        = valid_ff;
   assign rsp_chan.max_minerals = count_ff;

endmodule

`default_nettype wire

// File: hw/rtl/grid_max_path_count_top.sv
// Grid max path count: cells of an N by N grid arrive in row-major order, one
// occupancy bit per item, and the block returns the largest number of occupied
// cells on any right/down path from the top-left to the bottom-right corner,
// one count per grid, saturating at 31. One cell is accepted every clock
// cycle; the count appears in the result register the cycle after the
// bottom-right cell is taken. The per-cell work is a single pass through a
// one-row buffer (one write and one prefetched read per cycle), a compare and
// an add. The bottom-right cell waits only while an earlier count has not been
// taken. Writing the grid size (clamped to 1..MAX_SIDE) abandons any partial
// grid and starts a new one at the top-left cell.
`default_nettype none

module grid_max_path_count_top #(
   parameter int MAX_SIDE = 16
) (
   input  wire                clock,
   input  wire                reset,
   gmpc_req_if.sink           req_chan,
   gmpc_rsp_if.source         rsp_chan,
   input  wire                csr_write_enable,
   input  gmpc_pkg::size_type csr_write_data
);

   gmpc_pkg::result_type result;
   logic                 slot_free;

   gmpc_path_core #(
      .MAX_SIDE (MAX_SIDE)
   ) u_path_core (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .slot_free        (slot_free),
      .result           (result)
   );

   gmpc_result_reg u_result_reg (
      .clock     (clock),
      .reset     (reset),
      .result    (result),
      .slot_free (slot_free),
      .rsp_chan  (rsp_chan)
   );

endmodule

`default_nettype wire

// File: sim/testbench.sv
// self-checking testbench for the grid max path count block
`timescale 1ns / 1ps

module testbench;

   localparam int SIDE_LIMIT       = 16;
   localparam int RESET_CYCLES     = 12;
   localparam int DRAIN_CYCLES     = 4;
   localparam int LONG_HOLD_CYCLES = 120;
   localparam int CYCLE_LIMIT      = 200000;
   localparam int REPORT_LIMIT     = 10;

   logic               clock;
   logic               reset;
   logic               csr_write_enable;
   gmpc_pkg::size_type csr_write_data;

   gmpc_req_if req_if ();
   gmpc_rsp_if rsp_if ();

   grid_max_path_count_top #(.MAX_SIDE(SIDE_LIMIT)) dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_if),
      .rsp_chan         (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // path count prediction state
   gmpc_pkg::size_type  size_setting;
   gmpc_pkg::count_type column_best [SIDE_LIMIT];
   gmpc_pkg::count_type best_left;
   int                  cur_row;
   int                  cur_col;
   gmpc_pkg::count_type expected_counts [$];

   int failure_count;
   int cells_sent;
   int cycle_count;
   bit idling_on;
   bit long_hold_request;

   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   function automatic int side_of(input gmpc_pkg::size_type setting);
      if (setting == 0) return 1;
      if (setting > SIDE_LIMIT) return SIDE_LIMIT;
      return int'(setting);
   endfunction

   function automatic void clear_grid_progress();
      foreach (column_best[i]) column_best[i] = '0;
      best_left = '0;
      cur_row   = 0;
      cur_col   = 0;
   endfunction

   // best = cell + max(above, left), a neighbor outside the grid does not count
   function automatic void advance_path_count(input logic occupied);
      int side;
      int col;
      int prior;
      int best;
      side = side_of(size_setting);
      col  = (cur_col >= side) ? 0 : cur_col;
      if (cur_row >= side) cur_row = 0;
      prior = 0;
      if (cur_row > 0 && col > 0)
         prior = (column_best[col] > best_left) ? int'(column_best[col]) : int'(best_left);
      else if (cur_row > 0)
         prior = int'(column_best[col]);
      else if (col > 0)
         prior = int'(best_left);
      best = prior + int'(occupied);
      if (best > int'(gmpc_pkg::COUNT_MAX)) best = int'(gmpc_pkg::COUNT_MAX);
      column_best[col] = gmpc_pkg::count_type'(best);
      best_left        = gmpc_pkg::count_type'(best);
      if (cur_row == side - 1 && col == side - 1) begin
         expected_counts.push_back(gmpc_pkg::count_type'(best));
         clear_grid_progress();
      end else begin
         col++;
         if (col >= side) begin
            col = 0;
            cur_row++;
         end
         cur_col = col;
      end
   endfunction

   function automatic void check_count(input gmpc_pkg::count_type got);
      gmpc_pkg::count_type want;
      if (expected_counts.size() == 0) begin
         failure_count++;
         if (failure_count <= REPORT_LIMIT)
            $display("unexpected max_minerals %0d with no grid pending", got);
      end else begin
         want = expected_counts.pop_front();
         if (got !== want) begin
            failure_count++;
            if (failure_count <= REPORT_LIMIT)
               $display("max_minerals mismatch: expected %0d, got %0d", want, got);
         end
      end
   endfunction

   // outputs are stable at the falling edge, the item is taken at the next rising one
   always @(negedge clock) begin
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
         check_count(rsp_if.max_minerals);
   end

   initial begin : result_receiver
      int hold_left;
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_if.ready <= 1'b0;
         end else if (long_hold_request) begin
            rsp_if.ready <= 1'b0;
            for (hold_left = LONG_HOLD_CYCLES - 1; hold_left > 0; hold_left--)
               @(posedge clock);
            long_hold_request = 1'b0;
         end else if (idling_on && $urandom_range(0, 5) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(0, 6)) @(posedge clock);
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // called and returns at a rising edge; returns at the edge that takes the item
   task automatic send_cell(input logic occupied);
      if (idling_on && $urandom_range(0, 4) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_if.valid         <= 1'b1;
      req_if.cell_occupied <= occupied;
      @(negedge clock);
      while (req_if.ready !== 1'b1) @(negedge clock);
      @(posedge clock);
      advance_path_count(occupied);
      cells_sent++;
   endtask

   task automatic send_bits(input logic [31:0] bits, input int count);
      int i;
      for (i = 0; i < count; i++) send_cell(bits[i]);
   endtask

   task automatic send_grid(input int side, input int fill_percent);
      repeat (side * side) send_cell($urandom_range(0, 99) < fill_percent);
   endtask

   task automatic wait_until_drained();
      req_if.valid <= 1'b0;
      while (expected_counts.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_grid_size(input gmpc_pkg::size_type value);
      wait_until_drained();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      size_setting = value;
      clear_grid_progress();
   endtask

   task automatic test_largest_grid();
      // reset size, all occupied: the longest path reaches the largest count, 31
      send_grid(SIDE_LIMIT, 100);
      // out-of-range size clamps to the largest grid
      write_grid_size(gmpc_pkg::size_type'(31));
      send_grid(SIDE_LIMIT, 50);
   endtask

   task automatic test_single_cell_grids();
      write_grid_size(gmpc_pkg::size_type'(1));
      send_bits(32'b10, 2);
      // size zero acts as one
      write_grid_size(gmpc_pkg::size_type'(0));
      send_bits(32'b01, 2);
   endtask

   task automatic test_two_by_two();
      write_grid_size(gmpc_pkg::size_type'(2));
      send_bits(32'b1111, 4);
      send_bits(32'b0110, 4);
   endtask

   task automatic test_size_change_mid_grid();
      write_grid_size(gmpc_pkg::size_type'(3));
      send_bits(32'b111, 3);
      // partial grid is dropped, next item is a new top-left cell
      write_grid_size(gmpc_pkg::size_type'(2));
      send_bits(32'b1101, 4);
   endtask

   task automatic test_receiver_hold();
      write_grid_size(gmpc_pkg::size_type'(1));
      long_hold_request = 1'b1;
      repeat (40) send_cell($urandom_range(0, 1));
   endtask

   task automatic test_random_grids(input int cell_budget);
      int                 stop_at;
      int                 pick;
      int                 side;
      int                 grids;
      gmpc_pkg::size_type setting;
      stop_at = cells_sent + cell_budget;
      while (cells_sent < stop_at) begin
         pick = $urandom_range(0, 99);
         if (pick < 8)
            setting = gmpc_pkg::size_type'($urandom_range(0, 1));
         else if (pick < 70)
            setting = gmpc_pkg::size_type'($urandom_range(2, 6));
         else if (pick < 92)
            setting = gmpc_pkg::size_type'($urandom_range(7, 12));
         else if (pick < 96)
            setting = gmpc_pkg::size_type'($urandom_range(13, 16));
         else
            setting = gmpc_pkg::size_type'($urandom_range(17, 31));
         write_grid_size(setting);
         side = side_of(setting);
         if (side == 1)
            grids = $urandom_range(4, 20);
         else if (side <= 6)
            grids = $urandom_range(1, 4);
         else
            grids = 1;
         repeat (grids) send_grid(side, $urandom_range(0, 4) * 25);
         // trailing partial grid, dropped by the next size write
         if (side > 1 && $urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, side * side - 1)) send_cell($urandom_range(0, 1));
      end
   endtask

   task automatic test_back_to_back(input int cell_budget);
      int stop_at;
      int side;
      idling_on = 1'b0;
      stop_at = cells_sent + cell_budget;
      while (cells_sent < stop_at) begin
         side = $urandom_range(2, 5);
         write_grid_size(gmpc_pkg::size_type'(side));
         repeat (4) send_grid(side, $urandom_range(0, 4) * 25);
      end
   endtask

   initial begin
      reset                = 1'b1;
      req_if.valid         = 1'b0;
      req_if.cell_occupied = 1'b0;
      csr_write_enable     = 1'b0;
      csr_write_data       = gmpc_pkg::SIZE_RESET;
      idling_on            = 1'b1;
      long_hold_request    = 1'b0;
      failure_count        = 0;
      cells_sent           = 0;
      size_setting         = gmpc_pkg::SIZE_RESET;
      clear_grid_progress();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_largest_grid();
      test_single_cell_grids();
      test_two_by_two();
      test_size_change_mid_grid();
      test_receiver_hold();
      test_random_grids(540);
      test_back_to_back(340);

      wait_until_drained();
      if (failure_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
